/* rtl/mbet_pkg.sv */
`timescale 1ns / 1ps
// Package for the escape-time grid block: widths, reset values, sequencer
// codes and the saturation helpers. No dependencies.
package mbet_pkg;

   localparam int COORD_BITS       = 32;
   localparam int INDEX_BITS       = 13;
   localparam int SIZE_BITS        = 14;
   localparam int LIMIT_BITS       = 16;
   localparam int FRACT_OUT_BITS   = 17;
   localparam int FRACT_SHIFT      = 16;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 32;
   localparam int MAX_GRID_DEFAULT = 8192;

   localparam int FRAC_BITS  = 28;
   localparam int ITER_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * ITER_BITS;
   localparam int SQ_BITS    = PROD_BITS - FRAC_BITS;
   localparam int SUMSQ_BITS = SQ_BITS + 1;
   localparam int UPD_BITS   = SQ_BITS + 2;
   localparam int SUM_BITS   = 48;
   localparam int DVD_BITS   = 46;
   localparam int DVS_BITS   = 17;
   localparam int STEP_BITS  = $clog2(DVD_BITS);

   localparam logic [COORD_BITS-1:0] REAL_MIN_RESET = 32'hD800_0000;
   localparam logic [COORD_BITS-1:0] REAL_MAX_RESET = 32'h1000_0000;
   localparam logic [COORD_BITS-1:0] IMAG_MIN_RESET = 32'h1000_0000;
   localparam logic [COORD_BITS-1:0] IMAG_MAX_RESET = 32'hF000_0000;
   localparam logic [SIZE_BITS-1:0]  GRID_RESET     = 14'd1024;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET    = 16'd1000;

   localparam logic [SUMSQ_BITS-1:0] ESCAPE_RADIUS_SQ = SUMSQ_BITS'(4) << FRAC_BITS;
   localparam logic signed [ITER_BITS-1:0] ITER_HI = {2'b01, {(ITER_BITS-2){1'b0}}};
   localparam logic signed [ITER_BITS-1:0] ITER_LO = {2'b11, {(ITER_BITS-2){1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GRID_MUL,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_GRID_SUM,
      ST_ITER_START,
      ST_SQ_X,
      ST_SQ_Y,
      ST_CROSS,
      ST_UPDATE,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      JOB_RE,
      JOB_IM,
      JOB_FRAC
   } job_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_REAL_MIN,
      CSR_REAL_MAX,
      CSR_IMAG_MIN,
      CSR_IMAG_MAX,
      CSR_GRID_COLUMNS,
      CSR_GRID_ROWS,
      CSR_ITER_LIMIT
   } csr_index_type;

   function automatic logic signed [COORD_BITS-1:0] sat_coord(
      input logic signed [SUM_BITS-1:0] v);
      logic signed [SUM_BITS-1:0] hi;
      logic signed [SUM_BITS-1:0] lo;
      hi = SUM_BITS'({1'b0, {(COORD_BITS-1){1'b1}}});
      lo = ~hi;
      if (v > hi) begin
         sat_coord = hi[COORD_BITS-1:0];
      end else if (v < lo) begin
         sat_coord = lo[COORD_BITS-1:0];
      end else begin
         sat_coord = v[COORD_BITS-1:0];
      end
   endfunction

   function automatic logic signed [ITER_BITS-1:0] sat_iter(
      input logic signed [UPD_BITS-1:0] v);
      logic signed [UPD_BITS-1:0] hi;
      logic signed [UPD_BITS-1:0] lo;
      hi = {{(UPD_BITS-ITER_BITS){1'b0}}, ITER_HI};
      lo = {{(UPD_BITS-ITER_BITS){1'b1}}, ITER_LO};
      if (v > hi) begin
         sat_iter = ITER_HI;
      end else if (v < lo) begin
         sat_iter = ITER_LO;
      end else begin
         sat_iter = v[ITER_BITS-1:0];
      end
   endfunction

endpackage

/* rtl/mandelbrot_escape_time_grid.sv */
`timescale 1ns / 1ps
// Escape-time engine for one point per request: grid or supplied point, one
// shared multiplier and one shared restoring divider. Depends on mbet_pkg.
//
// Usage: a request on req_* names a grid point (req_func 0, from req_column and
// req_row) or a supplied point (req_func 1, req_given_re/req_given_im). One
// result per request appears on rsp_* with the point, the escape count and
// count/limit in Q1.16. Registers are written on the csr_* channel; the user
// must write them only while the block is idle, as the block itself does not
// enforce it; csr_ready is always high.
// Flow: req_ready is high only in the idle state, so one request is in work
// at a time. A supplied point runs a start state, then per iteration the steps
// x*x, y*y and x*y on the shared 33x33 multiplier and an update, then the
// one-bit-per-cycle divider (load plus 46 steps) for the fraction and an output
// state. A grid point first runs two passes of multiply, 46-step divide and sum
// for the coordinates; a grid size of zero skips that divide. With a limit of
// zero the divide is skipped. The result sits in an output register; the next
// request is taken while it waits, and a finished result holds the block in its
// output state until rsp_ready frees the one before it.
// Reset (synchronous) returns to idle, drops rsp_valid and loads the register
// defaults: real -2.5..1.0, imaginary 1.0..-1.0, 1024x1024 grid, limit 1000.
module mandelbrot_escape_time_grid #(
   parameter int MAX_GRID = mbet_pkg::MAX_GRID_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic                                      req_func,
   input  logic        [mbet_pkg::INDEX_BITS-1:0]     req_column,
   input  logic        [mbet_pkg::INDEX_BITS-1:0]     req_row,
   input  logic signed [mbet_pkg::COORD_BITS-1:0]     req_given_re,
   input  logic signed [mbet_pkg::COORD_BITS-1:0]     req_given_im,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [mbet_pkg::COORD_BITS-1:0]     rsp_point_re,
   output logic signed [mbet_pkg::COORD_BITS-1:0]     rsp_point_im,
   output logic        [mbet_pkg::LIMIT_BITS-1:0]     rsp_escape_count,
   output logic        [mbet_pkg::FRACT_OUT_BITS-1:0] rsp_escape_fraction,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic        [mbet_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic        [mbet_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import mbet_pkg::*;

   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(DVD_BITS - 1);
   localparam logic [DVS_BITS-1:0]  GRID_CAP  = DVS_BITS'(MAX_GRID);

   state_type state_ff, state_in;
   job_type   job_ff, job_in;

   logic signed [COORD_BITS-1:0] real_min_ff, real_min_in;
   logic signed [COORD_BITS-1:0] real_max_ff, real_max_in;
   logic signed [COORD_BITS-1:0] imag_min_ff, imag_min_in;
   logic signed [COORD_BITS-1:0] imag_max_ff, imag_max_in;
   logic [SIZE_BITS-1:0]         grid_columns_ff, grid_columns_in;
   logic [SIZE_BITS-1:0]         grid_rows_ff, grid_rows_in;
   logic [LIMIT_BITS-1:0]        iter_limit_ff, iter_limit_in;

   logic [INDEX_BITS-1:0]        column_ff, column_in;
   logic [INDEX_BITS-1:0]        row_ff, row_in;
   logic signed [COORD_BITS-1:0] cx_ff, cx_in;
   logic signed [COORD_BITS-1:0] cy_ff, cy_in;
   logic signed [ITER_BITS-1:0]  x_ff, x_in;
   logic signed [ITER_BITS-1:0]  y_ff, y_in;
   logic signed [SQ_BITS-1:0]    xx_ff, xx_in;
   logic signed [SQ_BITS-1:0]    yy_ff, yy_in;
   logic signed [PROD_BITS-1:0]  p_ff, p_in;
   logic [LIMIT_BITS-1:0]        count_ff, count_in;

   logic [DVD_BITS-1:0]          dvd_ff, dvd_in;
   logic [DVS_BITS-1:0]          rem_ff, rem_in;
   logic [DVS_BITS-1:0]          dvs_ff, dvs_in;
   logic [STEP_BITS-1:0]         step_ff, step_in;
   logic                         neg_ff, neg_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_BITS-1:0] rsp_point_re_ff, rsp_point_re_in;
   logic signed [COORD_BITS-1:0] rsp_point_im_ff, rsp_point_im_in;
   logic [LIMIT_BITS-1:0]        rsp_count_ff, rsp_count_in;
   logic [FRACT_OUT_BITS-1:0]    rsp_frac_ff, rsp_frac_in;

   logic signed [ITER_BITS-1:0]  mul_a;
   logic signed [ITER_BITS-1:0]  mul_b;
   logic signed [PROD_BITS-1:0]  prod;
   logic                         mul_en;
   logic [INDEX_BITS-1:0]        index_sel;
   logic [DVD_BITS:0]            p_low;
   logic [DVD_BITS:0]            p_mag;
   logic [DVS_BITS-1:0]          size_ext;
   logic [DVS_BITS-1:0]          size_eff;
   logic [DVD_BITS-1:0]          dividend_sel;
   logic [DVS_BITS-1:0]          divisor_sel;
   logic                         neg_sel;
   state_type                    div_next;
   logic [DVS_BITS:0]            rem_t;
   logic [DVS_BITS:0]            rem_sub;
   logic                         rem_ge;
   logic [SUM_BITS-1:0]          q_ext;
   logic signed [SUM_BITS-1:0]   q_signed;
   logic signed [COORD_BITS-1:0] lo_sel;
   logic signed [SUM_BITS-1:0]   lo_ext;
   logic signed [SUM_BITS-1:0]   grid_sum;
   logic signed [COORD_BITS-1:0] grid_coord;
   logic signed [UPD_BITS-1:0]   xx_w, yy_w, xy_w, cx_w, cy_w;
   logic signed [UPD_BITS-1:0]   upd_x, upd_y;
   logic [SUMSQ_BITS-1:0]        sumsq;
   logic [LIMIT_BITS-1:0]        count_inc;
   logic                         out_load;

   assign req_ready           = (state_ff == ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_point_re        = rsp_point_re_ff;
   assign rsp_point_im        = rsp_point_im_ff;
   assign rsp_escape_count    = rsp_count_ff;
   assign rsp_escape_fraction = rsp_frac_ff;

   assign prod = mul_a * mul_b;

   always_comb begin
      // shared datapath terms
      index_sel = (job_ff == JOB_IM) ? row_ff : column_ff;
      p_low     = p_ff[DVD_BITS:0];
      p_mag     = p_low[DVD_BITS] ? (~p_low + 1'b1) : p_low;
      size_ext  = {{(DVS_BITS-SIZE_BITS){1'b0}},
                   ((job_ff == JOB_IM) ? grid_rows_ff : grid_columns_ff)};
      size_eff  = (size_ext > GRID_CAP) ? GRID_CAP : size_ext;

      if (job_ff == JOB_FRAC) begin
         dividend_sel = {{(DVD_BITS-LIMIT_BITS-FRACT_SHIFT){1'b0}}, count_ff,
                         {FRACT_SHIFT{1'b0}}};
         divisor_sel  = {{(DVS_BITS-LIMIT_BITS){1'b0}}, iter_limit_ff};
         neg_sel      = 1'b0;
         div_next     = ST_OUT;
      end else begin
         dividend_sel = p_mag[DVD_BITS-1:0];
         divisor_sel  = size_eff;
         neg_sel      = p_low[DVD_BITS];
         div_next     = ST_GRID_SUM;
      end

      rem_t   = {rem_ff, dvd_ff[DVD_BITS-1]};
      rem_sub = rem_t - {1'b0, dvs_ff};
      rem_ge  = (rem_t >= {1'b0, dvs_ff});

      q_ext      = {{(SUM_BITS-DVD_BITS){1'b0}}, dvd_ff};
      q_signed   = neg_ff ? (~q_ext + 1'b1) : q_ext;
      lo_sel     = (job_ff == JOB_IM) ? imag_min_ff : real_min_ff;
      lo_ext     = {{(SUM_BITS-COORD_BITS){lo_sel[COORD_BITS-1]}}, lo_sel};
      grid_sum   = lo_ext + q_signed;
      grid_coord = sat_coord(grid_sum);

      xx_w  = {{(UPD_BITS-SQ_BITS){xx_ff[SQ_BITS-1]}}, xx_ff};
      yy_w  = {{(UPD_BITS-SQ_BITS){yy_ff[SQ_BITS-1]}}, yy_ff};
      xy_w  = {{(UPD_BITS-SQ_BITS){p_ff[PROD_BITS-1]}}, p_ff[PROD_BITS-1:FRAC_BITS]};
      cx_w  = {{(UPD_BITS-COORD_BITS){cx_ff[COORD_BITS-1]}}, cx_ff};
      cy_w  = {{(UPD_BITS-COORD_BITS){cy_ff[COORD_BITS-1]}}, cy_ff};
      upd_x = xx_w - yy_w + cx_w;
      upd_y = (xy_w <<< 1) + cy_w;
      sumsq = {1'b0, xx_ff} + {1'b0, yy_ff};
      count_inc = count_ff + 1'b1;

      out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

      // hold by default
      state_in        = state_ff;
      job_in          = job_ff;
      real_min_in     = real_min_ff;
      real_max_in     = real_max_ff;
      imag_min_in     = imag_min_ff;
      imag_max_in     = imag_max_ff;
      grid_columns_in = grid_columns_ff;
      grid_rows_in    = grid_rows_ff;
      iter_limit_in   = iter_limit_ff;
      column_in       = column_ff;
      row_in          = row_ff;
      cx_in           = cx_ff;
      cy_in           = cy_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      xx_in           = xx_ff;
      yy_in           = yy_ff;
      count_in        = count_ff;
      dvd_in          = dvd_ff;
      rem_in          = rem_ff;
      dvs_in          = dvs_ff;
      step_in         = step_ff;
      neg_in          = neg_ff;
      mul_a           = '0;
      mul_b           = '0;
      mul_en          = 1'b0;

      rsp_point_re_in = rsp_point_re_ff;
      rsp_point_im_in = rsp_point_im_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_frac_in     = rsp_frac_ff;
      rsp_valid_in    = rsp_ready ? 1'b0 : rsp_valid_ff;

      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_REAL_MIN:     real_min_in     = csr_wdata[COORD_BITS-1:0];
            CSR_REAL_MAX:     real_max_in     = csr_wdata[COORD_BITS-1:0];
            CSR_IMAG_MIN:     imag_min_in     = csr_wdata[COORD_BITS-1:0];
            CSR_IMAG_MAX:     imag_max_in     = csr_wdata[COORD_BITS-1:0];
            CSR_GRID_COLUMNS: grid_columns_in = csr_wdata[SIZE_BITS-1:0];
            CSR_GRID_ROWS:    grid_rows_in    = csr_wdata[SIZE_BITS-1:0];
            CSR_ITER_LIMIT:   iter_limit_in   = csr_wdata[LIMIT_BITS-1:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               column_in = req_column;
               row_in    = req_row;
               cx_in     = req_given_re;
               cy_in     = req_given_im;
               job_in    = JOB_RE;
               state_in  = req_func ? ST_ITER_START : ST_GRID_MUL;
            end
         end
         ST_GRID_MUL: begin
            mul_a    = (job_ff == JOB_IM)
                       ? ({imag_max_ff[COORD_BITS-1], imag_max_ff}
                          - {imag_min_ff[COORD_BITS-1], imag_min_ff})
                       : ({real_max_ff[COORD_BITS-1], real_max_ff}
                          - {real_min_ff[COORD_BITS-1], real_min_ff});
            mul_b    = {{(ITER_BITS-INDEX_BITS){1'b0}}, index_sel};
            mul_en   = 1'b1;
            state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            dvs_in  = divisor_sel;
            rem_in  = '0;
            step_in = '0;
            if (divisor_sel == '0) begin
               dvd_in   = '0;
               neg_in   = 1'b0;
               state_in = div_next;
            end else begin
               dvd_in   = dividend_sel;
               neg_in   = neg_sel;
               state_in = ST_DIV_RUN;
            end
         end
         ST_DIV_RUN: begin
            rem_in  = rem_ge ? rem_sub[DVS_BITS-1:0] : rem_t[DVS_BITS-1:0];
            dvd_in  = {dvd_ff[DVD_BITS-2:0], rem_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = div_next;
            end
         end
         ST_GRID_SUM: begin
            if (job_ff == JOB_RE) begin
               cx_in    = grid_coord;
               job_in   = JOB_IM;
               state_in = ST_GRID_MUL;
            end else begin
               cy_in    = grid_coord;
               state_in = ST_ITER_START;
            end
         end
         ST_ITER_START: begin
            x_in     = '0;
            y_in     = '0;
            count_in = '0;
            if (iter_limit_ff == '0) begin
               job_in   = JOB_FRAC;
               state_in = ST_DIV_LOAD;
            end else begin
               state_in = ST_SQ_X;
            end
         end
         ST_SQ_X: begin
            mul_a    = x_ff;
            mul_b    = x_ff;
            mul_en   = 1'b1;
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            xx_in    = p_ff[PROD_BITS-1:FRAC_BITS];
            mul_a    = y_ff;
            mul_b    = y_ff;
            mul_en   = 1'b1;
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            yy_in    = p_ff[PROD_BITS-1:FRAC_BITS];
            mul_a    = x_ff;
            mul_b    = y_ff;
            mul_en   = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            x_in     = sat_iter(upd_x);
            y_in     = sat_iter(upd_y);
            count_in = count_inc;
            if ((count_inc < iter_limit_ff) && (sumsq <= ESCAPE_RADIUS_SQ)) begin
               state_in = ST_SQ_X;
            end else begin
               job_in   = JOB_FRAC;
               state_in = ST_DIV_LOAD;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_point_re_in = cx_ff;
               rsp_point_im_in = cy_ff;
               rsp_count_in    = count_ff;
               rsp_frac_in     = dvd_ff[FRACT_OUT_BITS-1:0];
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      p_in = mul_en ? prod : p_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         job_ff          <= JOB_RE;
         real_min_ff     <= REAL_MIN_RESET;
         real_max_ff     <= REAL_MAX_RESET;
         imag_min_ff     <= IMAG_MIN_RESET;
         imag_max_ff     <= IMAG_MAX_RESET;
         grid_columns_ff <= GRID_RESET;
         grid_rows_ff    <= GRID_RESET;
         iter_limit_ff   <= LIMIT_RESET;
      end else begin
         rsp_valid_ff    <= rsp_valid_in;
         job_ff          <= job_in;
         real_min_ff     <= real_min_in;
         real_max_ff     <= real_max_in;
         imag_min_ff     <= imag_min_in;
         imag_max_ff     <= imag_max_in;
         grid_columns_ff <= grid_columns_in;
         grid_rows_ff    <= grid_rows_in;
         iter_limit_ff   <= iter_limit_in;
      end
   end

   always_ff @(posedge clock) begin
      column_ff       <= column_in;
      row_ff          <= row_in;
      cx_ff           <= cx_in;
      cy_ff           <= cy_in;
      x_ff            <= x_in;
      y_ff            <= y_in;
      xx_ff           <= xx_in;
      yy_ff           <= yy_in;
      p_ff            <= p_in;
      count_ff        <= count_in;
      dvd_ff          <= dvd_in;
      rem_ff          <= rem_in;
      dvs_ff          <= dvs_in;
      step_ff         <= step_in;
      neg_ff          <= neg_in;
      rsp_point_re_ff <= rsp_point_re_in;
      rsp_point_im_ff <= rsp_point_im_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_frac_ff     <= rsp_frac_in;
   end

   a_iter_below_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ_X) |-> (count_ff < iter_limit_ff))
      else $error("iteration started at or past the limit");

   a_iterate_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ_X) |-> ((x_ff <= ITER_HI) && (x_ff >= ITER_LO)
                                 && (y_ff <= ITER_HI) && (y_ff >= ITER_LO)))
      else $error("iterate outside saturation bounds");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_RUN) |-> (rem_ff < dvs_ff))
      else $error("divider remainder not below divisor");

   a_count_in_result: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (count_ff <= iter_limit_ff))
      else $error("escape count above limit");

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE) && !req_ready)
      else $error("request accepted without leaving idle");

endmodule
